// ----- src/frd_pkg.sv -----
// Shared types and constants of the flood relay with duplicate cache.
`default_nettype none

package frd_pkg;

   localparam int RELAY_DEPTH  = 8;
   localparam int SEEN_ENTRIES = 16;

   localparam logic [1:0] MODE_RECV    = 2'd0;
   localparam logic [1:0] MODE_PUBLISH = 2'd1;
   localparam logic [1:0] MODE_SEND    = 2'd2;

   typedef enum logic [2:0] {
      STAT_DUP        = 3'd0,
      STAT_QUEUED     = 3'd1,
      STAT_TTL_SPENT  = 3'd2,
      STAT_QUEUE_FULL = 3'd3,
      STAT_PUBLISHED  = 3'd4,
      STAT_SENT_RELAY = 3'd5,
      STAT_SENT_OWN   = 3'd6,
      STAT_NONE       = 3'd7
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOK
   } state_type;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  seq;
   } key_type;

   // Prefix flags that ripple along the seen table.
   typedef struct packed {
      logic found;
      logic free;
      logic dup;
   } chain_type;

   typedef struct packed {
      logic update;
      logic miss;
      logic full;
   } seen_ctl_type;

   typedef struct packed {
      logic push;
      logic pop;
   } relay_ctl_type;

   typedef struct packed {
      logic [15:0] word_2;
      logic [63:0] word_1;
      logic [63:0] word_0;
      logic [7:0]  ttl;
      logic [7:0]  seq;
      logic [15:0] node_id;
   } packet_type;

endpackage

`default_nettype wire

// ----- src/frd_seen_cell.sv -----
// One entry of the seen table with its match logic and chain flags.
`default_nettype none

module frd_seen_cell
   import frd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         is_head,
   input  wire key_type      key,
   input  wire seen_ctl_type ctl,
   input  wire chain_type    chain_in,
   output chain_type         chain_out,
   output logic              hit
);

   logic        valid_ff, valid_in;
   logic [15:0] origin_ff, origin_in;
   logic [7:0]  seq_ff, seq_in;
   logic        match, free_here, claim;

   assign match     = valid_ff && (origin_ff == key.id);
   assign hit       = match && !chain_in.found;
   assign free_here = !valid_ff && !chain_in.free;
   assign claim     = ctl.miss && (free_here || (ctl.full && is_head));

   assign chain_out.found = chain_in.found || match;
   assign chain_out.free  = chain_in.free || !valid_ff;
   assign chain_out.dup   = chain_in.dup || (hit && (seq_ff == key.seq));

   always_comb begin
      valid_in  = valid_ff;
      origin_in = origin_ff;
      seq_in    = seq_ff;
      if (ctl.update && hit) begin
         seq_in = key.seq;
      end else if (ctl.update && claim) begin
         valid_in  = 1'b1;
         origin_in = key.id;
         seq_in    = key.seq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      origin_ff <= origin_in;
      seq_ff    <= seq_in;
   end

endmodule

`default_nettype wire

// ----- src/frd_relay_cell.sv -----
// One slot of the shifting relay queue; the head slot is the oldest packet.
`default_nettype none

module frd_relay_cell
   import frd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire relay_ctl_type ctl,
   input  wire packet_type    push_pkt,
   input  wire packet_type    nxt_pkt,
   input  wire logic          nxt_vld,
   input  wire logic          prv_vld,
   output packet_type         pkt,
   output logic               vld
);

   logic       vld_ff, vld_in;
   packet_type pkt_ff, pkt_in;

   always_comb begin
      vld_in = vld_ff;
      pkt_in = pkt_ff;
      if (ctl.pop) begin
         vld_in = nxt_vld;
         pkt_in = nxt_pkt;
      end else if (ctl.push && !vld_ff && prv_vld) begin
         vld_in = 1'b1;
         pkt_in = push_pkt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff <= pkt_in;
   end

   assign pkt = pkt_ff;
   assign vld = vld_ff;

endmodule

`default_nettype wire

// ----- src/flood_relay_dedup_engine.sv -----
// Top level of the mesh flood relay with duplicate cache.
//
//   channel | direction | tuser         | tdata (lowest bit up)
//   req     | in        | mode[1:0]     | node_id, seq, ttl, sensor_word_0..2
//   rsp     | out       | status[2:0]   | out_node_id, out_seq, out_ttl, out_word_0..2
//   csr     | in        | index 0..1    | own_node_id, ttl_max
//
// Every beat is captured in ST_IDLE; in ST_LOOK the seen table
// cells compare the key and the relay queue cells shift or fill.
// A finished result waits in the output register while the next beat is taken.
// If that result is still unread, ST_LOOK holds until it is taken.
// Reset empties the seen table and the relay queue at once.
`default_nettype none

module flood_relay_dedup_engine
   import frd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [175:0] req_tdata,  // node_id, seq, ttl, sensor_word_0, _1, _2
   input  wire logic [1:0]   req_tuser,  // mode
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [175:0]      rsp_tdata,  // out_node_id, out_seq, out_ttl, out_word_0, _1, _2
   output logic [2:0]        rsp_tuser,  // status
   input  wire logic         csr_wr_en,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_wdata
);

   localparam logic CSR_OWN_NODE_ID = 1'b0;
   localparam logic CSR_TTL_MAX     = 1'b1;

   state_type    state_ff, state_in;
   logic [15:0]  own_node_id_ff;
   logic [7:0]   ttl_max_ff;
   logic [1:0]   mode_ff;
   packet_type   item_ff, item_in;
   packet_type   own_ff, own_in;
   logic         own_valid_ff, own_valid_in;
   logic [7:0]   own_seq_ff, own_seq_in;
   logic         rsp_valid_ff, rsp_valid_in;
   packet_type   rsp_pkt_ff, rsp_pkt_in;
   status_type   rsp_stat_ff, rsp_stat_in;

   key_type       key;
   seen_ctl_type  seen_ctl;
   relay_ctl_type relay_ctl;
   packet_type    push_pkt;
   chain_type     seen_chain [SEEN_ENTRIES+1];
   logic [SEEN_ENTRIES-1:0] seen_hit;
   packet_type    relay_pkt [RELAY_DEPTH];
   logic [RELAY_DEPTH-1:0]  relay_vld;
   logic          go, accept;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_id_ff <= '0;
         ttl_max_ff     <= 8'd3;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OWN_NODE_ID: own_node_id_ff <= csr_wdata;
            CSR_TTL_MAX:     ttl_max_ff     <= csr_wdata[7:0];
            default:         own_node_id_ff <= own_node_id_ff;
         endcase
      end
   end

   assign key.id  = item_ff.node_id;
   assign key.seq = item_ff.seq;

   assign seen_chain[0] = '0;

   for (genvar i = 0; i < SEEN_ENTRIES; i++) begin : g_seen
      frd_seen_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .is_head   (i == 0),
         .key       (key),
         .ctl       (seen_ctl),
         .chain_in  (seen_chain[i]),
         .chain_out (seen_chain[i+1]),
         .hit       (seen_hit[i])
      );
   end

   for (genvar i = 0; i < RELAY_DEPTH; i++) begin : g_relay
      packet_type nxt_pkt;
      logic       nxt_vld, prv_vld;
      if (i == RELAY_DEPTH - 1) begin : g_tail
         assign nxt_pkt = '0;
         assign nxt_vld = 1'b0;
      end else begin : g_mid
         assign nxt_pkt = relay_pkt[i+1];
         assign nxt_vld = relay_vld[i+1];
      end
      if (i == 0) begin : g_first
         assign prv_vld = 1'b1;
      end else begin : g_rest
         assign prv_vld = relay_vld[i-1];
      end
      frd_relay_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (relay_ctl),
         .push_pkt (push_pkt),
         .nxt_pkt  (nxt_pkt),
         .nxt_vld  (nxt_vld),
         .prv_vld  (prv_vld),
         .pkt      (relay_pkt[i]),
         .vld      (relay_vld[i])
      );
   end

   always_comb begin
      push_pkt     = item_ff;
      push_pkt.ttl = item_ff.ttl - 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         own_valid_ff <= 1'b0;
         own_seq_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         own_valid_ff <= own_valid_in;
         own_seq_ff   <= own_seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_tuser;
      end
      item_ff     <= item_in;
      own_ff      <= own_in;
      rsp_pkt_ff  <= rsp_pkt_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      own_in       = own_ff;
      own_valid_in = own_valid_ff;
      own_seq_in   = own_seq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pkt_in   = rsp_pkt_ff;
      rsp_stat_in  = rsp_stat_ff;
      seen_ctl     = '0;
      relay_ctl    = '0;
      req_tready   = 1'b0;
      go           = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               item_in = packet_type'(req_tdata);
               if (req_tuser == MODE_PUBLISH) begin
                  item_in.node_id = own_node_id_ff;
                  item_in.seq     = own_seq_ff;
                  item_in.ttl     = ttl_max_ff;
               end
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            go = !(rsp_valid_ff && !rsp_tready);
            if (go) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_pkt_in     = '0;
               rsp_stat_in    = STAT_NONE;
               seen_ctl.miss  = !seen_chain[SEEN_ENTRIES].found;
               seen_ctl.full  = !seen_chain[SEEN_ENTRIES].free;
               case (mode_ff)
                  MODE_RECV: begin
                     seen_ctl.update = 1'b1;
                     if (seen_chain[SEEN_ENTRIES].dup) begin
                        rsp_stat_in = STAT_DUP;
                     end else if (item_ff.ttl == 8'd0) begin
                        rsp_stat_in = STAT_TTL_SPENT;
                     end else if (relay_vld[RELAY_DEPTH-1]) begin
                        rsp_stat_in = STAT_QUEUE_FULL;
                     end else begin
                        relay_ctl.push = 1'b1;
                        rsp_stat_in    = STAT_QUEUED;
                     end
                  end
                  MODE_PUBLISH: begin
                     seen_ctl.update = 1'b1;
                     own_in          = item_ff;
                     own_valid_in    = 1'b1;
                     own_seq_in      = own_seq_ff + 8'd1;
                     rsp_pkt_in      = item_ff;
                     rsp_stat_in     = STAT_PUBLISHED;
                  end
                  MODE_SEND: begin
                     if (relay_vld[0]) begin
                        relay_ctl.pop = 1'b1;
                        rsp_pkt_in    = relay_pkt[0];
                        rsp_stat_in   = STAT_SENT_RELAY;
                     end else if (own_valid_ff) begin
                        rsp_pkt_in  = own_ff;
                        rsp_stat_in = STAT_SENT_OWN;
                     end
                  end
                  default: rsp_stat_in = STAT_NONE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pkt_ff;
   assign rsp_tuser  = rsp_stat_ff;

   a_seen_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(seen_hit))
      else $error("more than one seen entry matches the key");

   a_relay_packed: assert property (@(posedge clock) disable iff (reset)
      relay_vld[RELAY_DEPTH-1] |-> relay_vld[0])
      else $error("relay queue holds a gap");

   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOOK))
      else $error("accepted beat not processed");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      relay_ctl.push |-> !relay_vld[RELAY_DEPTH-1])
      else $error("push into a full relay queue");

endmodule

`default_nettype wire
